@@ rtl/core/tso_pkg.sv @@
`default_nettype none
// ============================================================================
// tso_pkg
// Shared widths, codes and types of the track section occupancy table.
// ============================================================================
package tso_pkg;

    // Fixed field widths
    localparam int OP_W       = 3;
    localparam int SEC_W      = 6;
    localparam int TRAIN_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int NSEC_CFG_W = 6;
    localparam int MAXT_W     = 5;
    localparam int MASK_W     = 32;

    // Register reset values
    localparam logic [NSEC_CFG_W-1:0] NUM_SECTIONS_RST = 6'd32;
    localparam logic [MAXT_W-1:0]     MAX_TRAINS_RST   = 5'd31;
    localparam logic [MASK_W-1:0]     ENTRY_MASK_RST   = 32'd0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_INSPECT     = 3'd0,
        OP_OCCUPY      = 3'd1,
        OP_RELEASE     = 3'd2,
        OP_INSERT      = 3'd3,
        OP_ENTRY_REQ   = 3'd4,
        OP_ENTRY_COMMIT = 3'd5,
        OP_ENTRY_CANCEL = 3'd6,
        OP_EXIT        = 3'd7
    } tso_op_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_OCC      = 3'd2,
        ST_NOTBUSY  = 3'd3,
        ST_LIMIT    = 3'd4,
        ST_NOTENTRY = 3'd5,
        ST_NOPEND   = 3'd6
    } tso_status_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_SECTIONS = 2'd0,
        CFG_MAX_TRAINS   = 2'd1,
        CFG_ENTRY_MASK   = 2'd2
    } tso_cfg_idx_e;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_LOOKUP = 1'b1
    } tso_state_e;

    // Decision of the op unit for one request
    typedef struct packed {
        tso_status_e status;
        logic        granted;
        logic        wr_en;
        logic        take_new;
        logic        count_dn;
    } tso_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/tso_if.sv @@
`default_nettype none
// ============================================================================
// tso_if
// Request, result and register write channels (valid/ready handshake).
// ============================================================================
interface tso_evt_if;
    logic              valid;
    logic              ready;
    tso_pkg::tso_op_e  op;
    logic [5:0]        section;
    logic [15:0]       train;

    modport source (output valid, op, section, train, input ready);
    modport sink   (input valid, op, section, train, output ready);
endinterface

interface tso_res_if;
    logic                  valid;
    logic                  ready;
    tso_pkg::tso_status_e  status;
    logic                  granted;
    logic                  busy_res;
    logic [15:0]           train_id;
    logic [5:0]            train_count;

    modport source (output valid, status, granted, busy_res, train_id, train_count,
                    input ready);
    modport sink   (input valid, status, granted, busy_res, train_id, train_count,
                    output ready);
endinterface

interface tso_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tso_ram.sv @@
`default_nettype none
// ============================================================================
// tso_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module tso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tso_op_unit.sv @@
`default_nettype none
// ============================================================================
// tso_op_unit
// Checks one request against the section entry and computes the new entry.
// ============================================================================
module tso_op_unit #(
    parameter int ID_W = 16
) (
    input  wire tso_pkg::tso_op_e op,
    input  wire logic             in_range,
    input  wire logic             is_entry,
    input  wire logic             full,
    input  wire logic [ID_W-1:0]  train,
    input  wire logic [ID_W-1:0]  next_id,
    input  wire logic             occ,
    input  wire logic             pend,
    input  wire logic [ID_W-1:0]  holder,
    output tso_pkg::tso_ctrl_t    ctrl,
    output logic                  occ_new,
    output logic                  pend_new,
    output logic [ID_W-1:0]       holder_new
);
    import tso_pkg::*;

    always_comb
    begin
        ctrl       = '{status: ST_OK, granted: 1'b0, wr_en: 1'b0,
                       take_new: 1'b0, count_dn: 1'b0};
        occ_new    = occ;
        pend_new   = pend;
        holder_new = holder;
        if (!in_range)
        begin
            ctrl.status = ST_RANGE;
        end
        else
        begin
            case (op)
                OP_OCCUPY:
                begin
                    if (occ) ctrl.status = ST_OCC;
                    else
                    begin
                        occ_new    = 1'b1;
                        holder_new = train;
                        ctrl.wr_en = 1'b1;
                    end
                end
                OP_RELEASE:
                begin
                    if (!occ) ctrl.status = ST_NOTBUSY;
                    else
                    begin
                        occ_new    = 1'b0;
                        holder_new = '0;
                        ctrl.wr_en = 1'b1;
                    end
                end
                OP_INSERT:
                begin
                    if (full) ctrl.status = ST_LIMIT;
                    else if (occ) ctrl.status = ST_OCC;
                    else
                    begin
                        occ_new       = 1'b1;
                        holder_new    = next_id;
                        ctrl.take_new = 1'b1;
                        ctrl.wr_en    = 1'b1;
                    end
                end
                OP_ENTRY_REQ:
                begin
                    if (full) ctrl.status = ST_LIMIT;
                    else if (!is_entry) ctrl.status = ST_NOTENTRY;
                    else if (!pend)
                    begin
                        pend_new     = 1'b1;
                        ctrl.granted = 1'b1;
                        ctrl.wr_en   = 1'b1;
                    end
                end
                OP_ENTRY_COMMIT:
                begin
                    if (!is_entry) ctrl.status = ST_NOTENTRY;
                    else if (!pend) ctrl.status = ST_NOPEND;
                    else if (occ) ctrl.status = ST_OCC;
                    else
                    begin
                        pend_new      = 1'b0;
                        occ_new       = 1'b1;
                        holder_new    = next_id;
                        ctrl.take_new = 1'b1;
                        ctrl.wr_en    = 1'b1;
                    end
                end
                OP_ENTRY_CANCEL:
                begin
                    if (!is_entry) ctrl.status = ST_NOTENTRY;
                    else if (!pend) ctrl.status = ST_NOPEND;
                    else
                    begin
                        pend_new   = 1'b0;
                        ctrl.wr_en = 1'b1;
                    end
                end
                OP_EXIT:
                begin
                    if (!is_entry) ctrl.status = ST_NOTENTRY;
                    else if (!occ) ctrl.status = ST_NOTBUSY;
                    else
                    begin
                        occ_new       = 1'b0;
                        holder_new    = '0;
                        ctrl.count_dn = 1'b1;
                        ctrl.wr_en    = 1'b1;
                    end
                end
                default:
                begin
                    ctrl.status = ST_OK;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/track_section_occupancy_table_unit.sv @@
`default_nettype none
// ============================================================================
// track_section_occupancy_table_unit
// Per-section occupancy table with train count, id counter and entry points.
// ============================================================================
// The table (busy flag, entry-pending flag and holder id per section) lives in
// one RAM with a registered read. A request is taken when the block is idle
// and the result register is empty or being drained; the following cycle reads
// the entry back, runs the checks, writes the updated entry and loads the
// result register. No new request is taken until the last one has loaded its
// result, and since only one request is in flight the write always lands
// before the next read, so no forwarding path exists. Each section has a
// valid flip-flop cleared by reset; an entry never written reads as free, so
// there is no clearing pass and the block is ready as soon as reset drops.
// Register writes are always taken and should be issued only while no request
// is outstanding. Sections at or above the smaller of num_sections and
// NUM_SECTIONS are out of range and report a free, idle section; entry points
// exist only below section 32.
module track_section_occupancy_table_unit #(
    parameter int NUM_SECTIONS  = 32,
    parameter int TRAIN_ID_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tso_cfg_if.sink     cfg,
    tso_evt_if.sink     evt,
    tso_res_if.source   res
);
    import tso_pkg::*;

    localparam int IDX_W   = $clog2(NUM_SECTIONS);
    localparam int ENTRY_W = TRAIN_ID_BITS + 2;
    localparam logic [SEC_W:0] SEC_LIMIT = (SEC_W + 1)'(NUM_SECTIONS);

    // Register file
    logic [NSEC_CFG_W-1:0] num_sections_reg;
    logic [MAXT_W-1:0]     max_trains_reg;
    logic [MASK_W-1:0]     entry_mask_reg;

    // Control and counters
    tso_state_e          state_reg, state_next;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [TRAIN_ID_BITS-1:0] next_id_reg, next_id_next;
    logic [NUM_SECTIONS-1:0]  valid_reg;

    // Held request
    tso_op_e                  op_reg;
    logic [SEC_W-1:0]         sec_reg;
    logic [TRAIN_ID_BITS-1:0] train_reg;

    // Result payload
    tso_status_e        status_reg;
    logic               granted_reg;
    logic               busy_reg;
    logic [TRAIN_W-1:0] train_id_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic accept;
    logic rd_en;
    logic tbl_wr;
    logic [IDX_W-1:0]   sec_idx;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] wr_data;

    logic in_range, is_entry, full;
    tso_ctrl_t ctrl;
    logic occ_new, pend_new;
    logic [TRAIN_ID_BITS-1:0] holder_new;
    logic show;

    // ---------------------------------------------------------------- config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sections_reg <= NUM_SECTIONS_RST;
            max_trains_reg   <= MAX_TRAINS_RST;
            entry_mask_reg   <= ENTRY_MASK_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_NUM_SECTIONS: num_sections_reg <= cfg.data[NSEC_CFG_W-1:0];
                CFG_MAX_TRAINS:   max_trains_reg   <= cfg.data[MAXT_W-1:0];
                CFG_ENTRY_MASK:   entry_mask_reg   <= cfg.data[MASK_W-1:0];
                default:          ;  // drop writes to unused indexes
            endcase
        end
    end

    // ----------------------------------------------------------- sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_LOOKUP;
            S_LOOKUP: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Take a request only when the result register will be free for it
    always_comb
    begin
        evt.ready = 1'b0;
        tbl_wr    = 1'b0;
        case (state_reg)
            S_IDLE:   evt.ready = !out_valid_reg || res.ready;
            S_LOOKUP: tbl_wr    = ctrl.wr_en;
            default:  evt.ready = 1'b0;
        endcase
    end

    assign accept = evt.valid && evt.ready;
    assign rd_en  = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            next_id_reg   <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LOOKUP)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            if (tbl_wr)
            begin
                valid_reg[sec_idx] <= 1'b1;
            end
        end
    end

    // Hold the request while its entry is read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= evt.op;
            sec_reg   <= evt.section;
            train_reg <= TRAIN_ID_BITS'(evt.train);
        end
    end

    // ---------------------------------------------------------------- table
    assign sec_idx = sec_reg[IDX_W-1:0];

    tso_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SECTIONS)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (sec_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (evt.section[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // A section never written reads as free
    assign entry   = valid_reg[sec_idx] ? rd_data : '0;
    assign wr_data = {pend_new, occ_new, holder_new};

    // ---------------------------------------------------------------- checks
    assign in_range = ({1'b0, sec_reg} < {1'b0, num_sections_reg})
                   && ({1'b0, sec_reg} < SEC_LIMIT);
    assign is_entry = !sec_reg[SEC_W-1] && entry_mask_reg[sec_reg[4:0]];
    assign full     = count_reg >= {1'b0, max_trains_reg};

    tso_op_unit #(
        .ID_W (TRAIN_ID_BITS)
    ) u_op (
        .op         (op_reg),
        .in_range   (in_range),
        .is_entry   (is_entry),
        .full       (full),
        .train      (train_reg),
        .next_id    (next_id_reg),
        .occ        (entry[TRAIN_ID_BITS]),
        .pend       (entry[TRAIN_ID_BITS+1]),
        .holder     (entry[TRAIN_ID_BITS-1:0]),
        .ctrl       (ctrl),
        .occ_new    (occ_new),
        .pend_new   (pend_new),
        .holder_new (holder_new)
    );

    // Advance the counters on a new train, lower the count on an exit; the count saturates at both ends
    always_comb
    begin
        count_next   = count_reg;
        next_id_next = next_id_reg;
        if (state_reg == S_LOOKUP)
        begin
            if (ctrl.take_new)
            begin
                next_id_next = next_id_reg + 1'b1;
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else if (ctrl.count_dn && (count_reg != '0))
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    // --------------------------------------------------------------- result
    assign show = in_range && occ_new;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOOKUP)
        begin
            status_reg    <= ctrl.status;
            granted_reg   <= ctrl.granted;
            busy_reg      <= show;
            train_id_reg  <= show ? TRAIN_W'(holder_new) : '0;
            count_out_reg <= count_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = status_reg;
    assign res.granted     = granted_reg;
    assign res.busy_res    = busy_reg;
    assign res.train_id    = train_id_reg;
    assign res.train_count = count_out_reg;

endmodule
`default_nettype wire
